@@ src/chained_hash_set_insert_lookup_core_assert.svh @@
// Assertion macros for the chained hash set core.
// Needs signals clk and rst_n in the scope of each use.
`ifndef CHAINED_HASH_SET_INSERT_LOOKUP_CORE_ASSERT_SVH
`define CHAINED_HASH_SET_INSERT_LOOKUP_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define CHS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/chs_pkg.sv @@
// Package for the chained hash set core: field widths, codes and the
// byte-wise mod 5 step of the bucket hash. No dependencies.
package chs_pkg;

    localparam int KEY_W            = 31;
    localparam int NUM_ROWS         = 5;
    localparam int NUM_COLS         = 8;
    localparam int NUM_BUCKETS      = NUM_ROWS * NUM_COLS;
    localparam int BUCKET_W         = 6;
    localparam int BUCKET_DEPTH_DEF = 8;
    localparam int HASH_STEPS       = 4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_INSERTED  = 2'd0,
        STATUS_FOUND     = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    // Fold one key byte into a running remainder mod 5 (256 = 1 and 16 = 1 mod 5)
    function automatic logic [2:0] mod5_step(input logic [2:0] acc, input logic [7:0] data);
        logic [8:0] v;
        logic [5:0] s;
        v = {6'b0, acc} + {1'b0, data};
        s = {1'b0, v[8:4]} + {2'b0, v[3:0]};
        if (s >= 6'd40) s = s - 6'd40;
        if (s >= 6'd20) s = s - 6'd20;
        if (s >= 6'd10) s = s - 6'd10;
        if (s >= 6'd5)  s = s - 6'd5;
        return s[2:0];
    endfunction

endpackage

@@ src/chained_hash_set_insert_lookup_core.sv @@
// Chained hash set of 31-bit keys with insert and find commands.
// Uses chs_pkg and the assertion macros in chained_hash_set_insert_lookup_core_assert.svh.
//
// Usage:
//   Command channel (cmd_valid, cmd_stall, command, key): command 0 inserts
//   key into its bucket, command 1 looks it up. The bucket is row = key mod 5,
//   column = key bits 5..3, each holding BUCKET_DEPTH keys.
//   Result channel (res_valid, res_stall, status): one item per command,
//   status 0 inserted, 1 found, 2 not found, 3 bucket full (insert dropped).
//   Sequence: the mod 5 unit folds one key byte per cycle in ST_HASH, then
//   ST_FILL_RD reads the bucket fill count and ST_DECIDE decides. A find
//   then walks the bucket in ST_WALK through the single key memory read
//   port, one compare per cycle. One command is in flight at a time;
//   cmd_stall is low only while the sequencer is idle.
//   Reset empties every bucket at once (per-bucket valid bits), so commands
//   are taken right after reset. A stalled result stays in the output
//   register; the sequencer holds a finished result until that register frees.
`include "chained_hash_set_insert_lookup_core_assert.svh"

module chained_hash_set_insert_lookup_core
#(
    parameter int BUCKET_DEPTH = chs_pkg::BUCKET_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_stall,
    input  logic                     command,
    input  logic [chs_pkg::KEY_W-1:0] key,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic [1:0]               status
);
    import chs_pkg::*;

    localparam int FW    = $clog2(BUCKET_DEPTH + 1);
    localparam int SW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int AW    = $clog2(SLOTS);
    localparam logic [FW-1:0] DEPTH_F = FW'(BUCKET_DEPTH);
    localparam logic [AW-1:0] DEPTH_A = AW'(BUCKET_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_FILL_RD,
        ST_DECIDE,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic                  cmd_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [KEY_W-1:0]      sh_reg, sh_next;
    logic [2:0]            acc_reg, acc_next;
    logic [1:0]            step_reg, step_next;
    logic [BUCKET_W-1:0]   bucket_reg;
    logic [AW-1:0]         base_reg;
    logic [FW-1:0]         fill_reg, fill_next;
    logic [FW-1:0]         slot_reg, slot_next;
    status_t               result_reg, result_next;
    logic                  res_valid_reg, res_valid_next;
    status_t               status_reg, status_next;

    logic [BUCKET_W-1:0]   bucket_cur;
    logic [FW-1:0]         fill_cur;

    // Bucket fill counts: memory plus one valid bit per bucket
    logic [FW-1:0]         fill_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] fill_vld_reg;
    logic [FW-1:0]         fill_rd_reg;
    logic                  fill_vld_rd_reg;
    logic                  fill_we;

    // Key store: one write and one read port, registered read data
    logic [KEY_W-1:0]      key_mem [SLOTS];
    logic [KEY_W-1:0]      key_rd_reg;
    logic                  key_we;
    logic                  key_re;
    logic [AW-1:0]         key_rd_addr;
    logic [AW-1:0]         key_wr_addr;

    assign bucket_cur  = {acc_reg, key_reg[5:3]};
    assign fill_cur    = fill_vld_rd_reg ? fill_rd_reg : '0;
    assign key_wr_addr = base_reg + AW'(fill_cur[SW-1:0]);

    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign status    = status_reg;

    // Sequencer next-state logic
    always_comb
    begin
        state_next     = state_reg;
        sh_next        = sh_reg;
        acc_next       = acc_reg;
        step_next      = step_reg;
        fill_next      = fill_reg;
        slot_next      = slot_reg;
        result_next    = result_reg;
        res_valid_next = res_valid_reg && res_stall;
        status_next    = status_reg;
        fill_we        = 1'b0;
        key_we         = 1'b0;
        key_re         = 1'b0;
        key_rd_addr    = base_reg + AW'(slot_reg[SW-1:0]);

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    sh_next    = key;
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                // Fold one byte per cycle into the row remainder
                acc_next  = mod5_step(acc_reg, sh_reg[7:0]);
                sh_next   = sh_reg >> 8;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'(HASH_STEPS - 1))
                begin
                    state_next = ST_FILL_RD;
                end
            end
            ST_FILL_RD:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                fill_next = fill_cur;
                if (cmd_reg == CMD_INSERT)
                begin
                    if (fill_cur >= DEPTH_F)
                    begin
                        result_next = STATUS_FULL;
                    end
                    else
                    begin
                        key_we      = 1'b1;
                        fill_we     = 1'b1;
                        result_next = STATUS_INSERTED;
                    end
                    state_next = ST_DONE;
                end
                else if (fill_cur == '0)
                begin
                    result_next = STATUS_NOT_FOUND;
                    state_next  = ST_DONE;
                end
                else
                begin
                    // Issue the read of the first slot
                    key_re      = 1'b1;
                    key_rd_addr = base_reg;
                    slot_next   = FW'(1);
                    state_next  = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // Compare the slot read last cycle, issue the next one
                if (key_rd_reg == key_reg)
                begin
                    result_next = STATUS_FOUND;
                    state_next  = ST_DONE;
                end
                else if (slot_reg == fill_reg)
                begin
                    result_next = STATUS_NOT_FOUND;
                    state_next  = ST_DONE;
                end
                else
                begin
                    key_re    = 1'b1;
                    slot_next = slot_reg + FW'(1);
                end
            end
            ST_DONE:
            begin
                // Hand the result to the output register once it is free
                if (!(res_valid_reg && res_stall))
                begin
                    res_valid_next = 1'b1;
                    status_next    = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, control and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            slot_reg      <= '0;
            res_valid_reg <= 1'b0;
            status_reg    <= STATUS_INSERTED;
            result_reg    <= STATUS_INSERTED;
            fill_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            slot_reg      <= slot_next;
            res_valid_reg <= res_valid_next;
            status_reg    <= status_next;
            result_reg    <= result_next;
            if (fill_we)
            begin
                fill_vld_reg[bucket_reg] <= 1'b1;
            end
        end
    end

    // Capture the item and working values
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid)
        begin
            cmd_reg <= command;
            key_reg <= key;
        end
        if (state_reg == ST_FILL_RD)
        begin
            bucket_reg      <= bucket_cur;
            base_reg        <= AW'(bucket_cur) * DEPTH_A;
            fill_vld_rd_reg <= fill_vld_reg[bucket_cur];
        end
        sh_reg   <= sh_next;
        acc_reg  <= acc_next;
        fill_reg <= fill_next;
    end

    // Fill count memory
    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[bucket_reg] <= fill_cur + FW'(1);
        end
        if (state_reg == ST_FILL_RD)
        begin
            fill_rd_reg <= fill_mem[bucket_cur];
        end
    end

    // Key memory
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wr_addr] <= key_reg;
        end
        if (key_re)
        begin
            key_rd_reg <= key_mem[key_rd_addr];
        end
    end

    `CHS_ASSERT_NEXT(a_accept_starts_hash, cmd_valid && !cmd_stall, state_reg == ST_HASH,
        "accepted item did not start the hash")
    `CHS_ASSERT_SAME(a_walk_bounds, state_reg == ST_WALK,
        (slot_reg <= fill_reg) && (fill_reg != '0) && (fill_reg <= DEPTH_F),
        "bucket walk out of range")
    `CHS_ASSERT_NEXT(a_insert_marks_bucket,
        state_reg == ST_DECIDE && cmd_reg == CMD_INSERT && fill_cur < DEPTH_F,
        fill_vld_reg[bucket_reg], "insert did not mark its bucket")
    `CHS_ASSERT_NEXT(a_done_delivers,
        state_reg == ST_DONE && !(res_valid && res_stall),
        state_reg == ST_IDLE && res_valid, "finished result not delivered")

endmodule
